/* design/mbb_pkg.sv */
// mbb_pkg: widths, register indexes, reset values and control structs
// for the beta-binomial metropolis step block; no dependencies
package mbb_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int THETA_W    = FRAC_BITS + 1;
   localparam int LOG_INT_W  = 7;
   localparam int LOG_W      = FRAC_BITS + LOG_INT_W;
   localparam int POS_W      = $clog2(FRAC_BITS);
   localparam int CNT_W      = $clog2(FRAC_BITS);
   localparam int MUL_A_W    = 27;
   localparam int MUL_B_W    = 31;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;
   localparam int WIDTH_W    = 26;
   localparam int CNT16_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SUCCESSES   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIALS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIOR_ALPHA = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIOR_BETA  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_THETA = 3'd5;

   localparam logic [CNT16_W-1:0] RST_SUCCESSES   = 16'd7;
   localparam logic [CNT16_W-1:0] RST_TRIALS      = 16'd10;
   localparam logic [CNT16_W-1:0] RST_PRIOR_ALPHA = 16'd512;
   localparam logic [CNT16_W-1:0] RST_PRIOR_BETA  = 16'd512;
   localparam logic [WIDTH_W-1:0] RST_PROP_WIDTH  = 26'd15099494;
   localparam logic [THETA_W-1:0] RST_START_THETA = 25'd8388608;

   localparam logic [THETA_W-1:0] ONE_Q = THETA_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic start;
   } log_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } log_stat_type;

endpackage

/* design/mbb_channels.sv */
// mbb channel interfaces: request, response and register write channels
// depends on mbb_pkg
interface mbb_req_if;
   logic                           valid;
   logic                           ready;
   logic [mbb_pkg::FRAC_BITS-1:0]  step_random;
   logic [mbb_pkg::FRAC_BITS-1:0]  accept_random;
   logic                           restart;
   modport source (output valid, step_random, accept_random, restart, input ready);
   modport sink (input valid, step_random, accept_random, restart, output ready);
endinterface

interface mbb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mbb_pkg::THETA_W-1:0]   sample_theta;
   logic                          accepted;
   logic                          out_of_range;
   modport source (output valid, sample_theta, accepted, out_of_range, input ready);
   modport sink (input valid, sample_theta, accepted, out_of_range, output ready);
endinterface

interface mbb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mbb_pkg::CSR_IDX_W-1:0]   index;
   logic [mbb_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/mbb_mul.sv */
// mbb_mul: the shared signed multiplier used for squaring, offset and ratio terms
// depends on mbb_pkg
module mbb_mul (
   input  logic signed [mbb_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [mbb_pkg::MUL_B_W-1:0] op_b,
   output logic signed [mbb_pkg::PROD_W-1:0]  prod
);
   logic signed [mbb_pkg::PROD_W-1:0] a_ext;
   logic signed [mbb_pkg::PROD_W-1:0] b_ext;

   assign a_ext = mbb_pkg::PROD_W'(op_a);
   assign b_ext = mbb_pkg::PROD_W'(op_b);
   assign prod  = a_ext * b_ext;
endmodule

/* design/mbb_log.sv */
// mbb_log: base-2 log sequencer, leading-one normalize then one squaring per cycle
// depends on mbb_pkg; squares through the shared multiplier via sq_op/prod
module mbb_log (
   input  logic                                clock,
   input  logic                                reset,
   input  mbb_pkg::log_ctrl_type               ctrl,
   input  logic [mbb_pkg::FRAC_BITS-1:0]       x,
   input  logic signed [mbb_pkg::PROD_W-1:0]   prod,
   output logic [mbb_pkg::FRAC_BITS:0]         sq_op,
   output mbb_pkg::log_stat_type               stat,
   output logic signed [mbb_pkg::LOG_W-1:0]    result
);
   logic [mbb_pkg::FRAC_BITS:0]     m_ff, m_in;
   logic [mbb_pkg::FRAC_BITS-1:0]   frac_ff, frac_in;
   logic [mbb_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [mbb_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [mbb_pkg::POS_W-1:0]       pos;
   logic [mbb_pkg::FRAC_BITS+1:0]   sq;
   logic                            last;

   always_comb begin
      pos = '0;
      for (int i = 0; i < mbb_pkg::FRAC_BITS; i++) begin
         if (x[i]) begin
            pos = mbb_pkg::POS_W'(i);
         end
      end
   end

   assign sq   = prod[2*mbb_pkg::FRAC_BITS+1:mbb_pkg::FRAC_BITS];
   assign last = (cnt_ff == mbb_pkg::CNT_W'(mbb_pkg::FRAC_BITS - 1));

   always_comb begin
      m_in    = m_ff;
      frac_in = frac_ff;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         m_in    = {1'b0, x} << (mbb_pkg::POS_W'(mbb_pkg::FRAC_BITS) - pos);
         frac_in = '0;
         pos_in  = pos;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         m_in    = sq[mbb_pkg::FRAC_BITS+1] ? sq[mbb_pkg::FRAC_BITS+1:1]
                                            : sq[mbb_pkg::FRAC_BITS:0];
         frac_in = {frac_ff[mbb_pkg::FRAC_BITS-2:0], sq[mbb_pkg::FRAC_BITS+1]};
         cnt_in  = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      m_ff    <= m_in;
      frac_ff <= frac_in;
      pos_ff  <= pos_in;
      cnt_ff  <= cnt_in;
   end

   assign sq_op       = m_ff;
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign result      = {mbb_pkg::LOG_INT_W'(pos_ff) - mbb_pkg::LOG_INT_W'(mbb_pkg::FRAC_BITS),
                         frac_ff};
endmodule

/* design/metropolis_beta_binomial_step.sv */
// metropolis_beta_binomial_step: random-walk metropolis step for a beta-binomial posterior
// depends on mbb_pkg, mbb_channels, mbb_mul and mbb_log
//
// usage
//   req_ch carries one step: step_random r, accept_random u and restart.
//   rsp_ch returns one result per request: sample_theta, accepted, out_of_range.
//   csr_ch writes the six registers by index, always ready; write only when idle.
// sequencing
//   a request is taken only when idle and the response register is empty.
//   one log runs on the shared squaring loop: start, one squaring per fraction bit, done.
//   an out-of-range proposal is answered without any log; an in-range one with a zero
//   acceptance draw after the two proposal logs, and any other after the log of u
//   and the ratio compare; restart first clamps the start value and takes its two logs.
//   one request in flight; the next is taken the cycle after the response goes.
// reset
//   loads register defaults, then computes the logs of the start value
//   before req_ch.ready rises.
// stall
//   a result waits in the response register; no new request is taken until it goes.
module metropolis_beta_binomial_step (
   input logic        clock,
   input logic        reset,
   mbb_req_if.sink    req_ch,
   mbb_rsp_if.source  rsp_ch,
   mbb_csr_if.sink    csr_ch
);
   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_LOGT = 4'd1;
   localparam logic [3:0] S_LOGC = 4'd2;
   localparam logic [3:0] S_IDLE = 4'd3;
   localparam logic [3:0] S_OFF  = 4'd4;
   localparam logic [3:0] S_PROP = 4'd5;
   localparam logic [3:0] S_PLT  = 4'd6;
   localparam logic [3:0] S_PLC  = 4'd7;
   localparam logic [3:0] S_LU   = 4'd8;
   localparam logic [3:0] S_MA   = 4'd9;
   localparam logic [3:0] S_MB   = 4'd10;
   localparam logic [3:0] S_CMP  = 4'd11;

   localparam int FB = mbb_pkg::FRAC_BITS;

   logic [3:0] state_ff, state_in;
   logic       go_ff, go_in;
   logic       job_ff, job_in;

   logic [mbb_pkg::CNT16_W-1:0]  succ_ff, trials_ff, alpha_ff, beta_ff;
   logic [mbb_pkg::WIDTH_W-1:0]  width_ff;
   logic [mbb_pkg::THETA_W-1:0]  start_ff;

   logic [mbb_pkg::THETA_W-1:0]       theta_ff, theta_in;
   logic signed [mbb_pkg::LOG_W-1:0]  clt_ff, clt_in, clc_ff, clc_in;
   logic signed [mbb_pkg::LOG_W-1:0]  lt_ff, lt_in, lc_ff, lc_in, lu_ff, lu_in;
   logic [FB-1:0]                     tp_ff, tp_in, r_ff, r_in, u_ff, u_in;
   logic signed [mbb_pkg::PROD_W-1:0] prod_ff, pa_ff, pa_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mbb_pkg::THETA_W-1:0]  rsp_theta_ff, rsp_theta_in;
   logic                         rsp_acc_ff, rsp_acc_in, rsp_oor_ff, rsp_oor_in;

   mbb_pkg::log_ctrl_type            log_ctrl;
   mbb_pkg::log_stat_type            log_st;
   logic [FB-1:0]                    log_x;
   logic [FB:0]                      sq_op;
   logic signed [mbb_pkg::LOG_W-1:0] log_res;

   logic signed [mbb_pkg::MUL_A_W-1:0] op_a;
   logic signed [mbb_pkg::MUL_B_W-1:0] op_b;
   logic signed [mbb_pkg::PROD_W-1:0]  mul_p;

   logic signed [mbb_pkg::WIDTH_W-1:0]  centered;
   logic signed [mbb_pkg::PROD_W-FB-1:0] offset;
   logic signed [mbb_pkg::PROD_W-FB+1:0] prop;
   logic [mbb_pkg::CNT16_W-1:0]          fail;
   logic signed [mbb_pkg::MUL_A_W-1:0]   ca, cb;
   logic signed [mbb_pkg::MUL_B_W-1:0]   dlt, dlc;
   logic signed [mbb_pkg::PROD_W-1:0]    ratio, lu_scaled;
   logic [mbb_pkg::THETA_W-1:0]          start_clamped;
   logic                                 take_req, next_is_log;

   mbb_mul u_mul (.op_a(op_a), .op_b(op_b), .prod(mul_p));

   mbb_log u_log (
      .clock(clock), .reset(reset), .ctrl(log_ctrl), .x(log_x), .prod(mul_p),
      .sq_op(sq_op), .stat(log_st), .result(log_res)
   );

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         succ_ff   <= mbb_pkg::RST_SUCCESSES;
         trials_ff <= mbb_pkg::RST_TRIALS;
         alpha_ff  <= mbb_pkg::RST_PRIOR_ALPHA;
         beta_ff   <= mbb_pkg::RST_PRIOR_BETA;
         width_ff  <= mbb_pkg::RST_PROP_WIDTH;
         start_ff  <= mbb_pkg::RST_START_THETA;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            mbb_pkg::CSR_SUCCESSES:   succ_ff   <= csr_ch.data[mbb_pkg::CNT16_W-1:0];
            mbb_pkg::CSR_TRIALS:      trials_ff <= csr_ch.data[mbb_pkg::CNT16_W-1:0];
            mbb_pkg::CSR_PRIOR_ALPHA: alpha_ff  <= csr_ch.data[mbb_pkg::CNT16_W-1:0];
            mbb_pkg::CSR_PRIOR_BETA:  beta_ff   <= csr_ch.data[mbb_pkg::CNT16_W-1:0];
            mbb_pkg::CSR_PROP_WIDTH:  width_ff  <= csr_ch.data[mbb_pkg::WIDTH_W-1:0];
            mbb_pkg::CSR_START_THETA: start_ff  <= csr_ch.data[mbb_pkg::THETA_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath terms
   assign start_clamped = (start_ff == '0) ? mbb_pkg::THETA_W'(1) :
                          (start_ff >= mbb_pkg::ONE_Q) ? mbb_pkg::ONE_Q - 1'b1 : start_ff;
   assign centered  = $signed({1'b0, r_ff, 1'b0}) - $signed(mbb_pkg::WIDTH_W'(mbb_pkg::ONE_Q));
   assign offset    = prod_ff[mbb_pkg::PROD_W-1:FB];
   assign prop      = $signed({{(mbb_pkg::PROD_W-FB+2-mbb_pkg::THETA_W){1'b0}}, theta_ff})
                      + (mbb_pkg::PROD_W-FB+2)'(offset);
   assign fail      = (trials_ff > succ_ff) ? trials_ff - succ_ff : '0;
   assign ca        = $signed({3'b0, succ_ff, 8'b0}) + $signed({11'b0, alpha_ff})
                      - mbb_pkg::MUL_A_W'(256);
   assign cb        = $signed({3'b0, fail, 8'b0}) + $signed({11'b0, beta_ff})
                      - mbb_pkg::MUL_A_W'(256);
   assign dlt       = lt_ff - clt_ff;
   assign dlc       = lc_ff - clc_ff;
   assign ratio     = pa_ff + prod_ff;
   assign lu_scaled = mbb_pkg::PROD_W'($signed({lu_ff, 8'b0}));

   always_comb begin
      if (log_st.busy) begin
         op_a = $signed({{(mbb_pkg::MUL_A_W-FB-1){1'b0}}, sq_op});
         op_b = $signed({{(mbb_pkg::MUL_B_W-FB-1){1'b0}}, sq_op});
      end else begin
         case (state_ff)
            S_OFF: begin
               op_a = $signed({1'b0, width_ff});
               op_b = mbb_pkg::MUL_B_W'(centered);
            end
            S_MA: begin
               op_a = ca;
               op_b = dlt;
            end
            default: begin
               op_a = cb;
               op_b = dlc;
            end
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         S_LOGT:  log_x = theta_ff[FB-1:0];
         S_LOGC:  log_x = FB'(mbb_pkg::ONE_Q - theta_ff);
         S_PLT:   log_x = tp_ff;
         S_PLC:   log_x = FB'(mbb_pkg::ONE_Q - {1'b0, tp_ff});
         default: log_x = u_ff;
      endcase
   end

   assign log_ctrl.start = go_ff;
   assign take_req       = req_ch.valid && req_ch.ready;
   assign req_ch.ready   = (state_ff == S_IDLE) && !rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      theta_in     = theta_ff;
      clt_in       = clt_ff;
      clc_in       = clc_ff;
      lt_in        = lt_ff;
      lc_in        = lc_ff;
      lu_in        = lu_ff;
      tp_in        = tp_ff;
      r_in         = r_ff;
      u_in         = u_ff;
      pa_in        = pa_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_theta_in = rsp_theta_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_oor_in   = rsp_oor_ff;
      case (state_ff)
         S_INIT: begin
            theta_in = start_clamped;
            state_in = S_LOGT;
         end
         S_LOGT: begin
            if (log_st.done) begin
               clt_in   = log_res;
               state_in = S_LOGC;
            end
         end
         S_LOGC: begin
            if (log_st.done) begin
               clc_in   = log_res;
               state_in = job_ff ? S_OFF : S_IDLE;
            end
         end
         S_IDLE: begin
            if (take_req) begin
               r_in     = req_ch.step_random;
               u_in     = req_ch.accept_random;
               job_in   = 1'b1;
               state_in = req_ch.restart ? S_INIT : S_OFF;
            end
         end
         S_OFF: state_in = S_PROP;
         S_PROP: begin
            if (prop <= 0 || prop >= $signed((mbb_pkg::PROD_W-FB+2)'(mbb_pkg::ONE_Q))) begin
               rsp_valid_in = 1'b1;
               rsp_theta_in = theta_ff;
               rsp_acc_in   = 1'b0;
               rsp_oor_in   = 1'b1;
               job_in       = 1'b0;
               state_in     = S_IDLE;
            end else begin
               tp_in    = prop[FB-1:0];
               state_in = S_PLT;
            end
         end
         S_PLT: begin
            if (log_st.done) begin
               lt_in    = log_res;
               state_in = S_PLC;
            end
         end
         S_PLC: begin
            if (log_st.done) begin
               lc_in = log_res;
               if (u_ff == '0) begin
                  theta_in     = {1'b0, tp_ff};
                  clt_in       = lt_ff;
                  clc_in       = log_res;
                  rsp_valid_in = 1'b1;
                  rsp_theta_in = {1'b0, tp_ff};
                  rsp_acc_in   = 1'b1;
                  rsp_oor_in   = 1'b0;
                  job_in       = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_LU;
               end
            end
         end
         S_LU: begin
            if (log_st.done) begin
               lu_in    = log_res;
               state_in = S_MA;
            end
         end
         S_MA: state_in = S_MB;
         S_MB: begin
            pa_in    = prod_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            rsp_valid_in = 1'b1;
            rsp_oor_in   = 1'b0;
            job_in       = 1'b0;
            state_in     = S_IDLE;
            if (lu_scaled < ratio) begin
               theta_in     = {1'b0, tp_ff};
               clt_in       = lt_ff;
               clc_in       = lc_ff;
               rsp_theta_in = {1'b0, tp_ff};
               rsp_acc_in   = 1'b1;
            end else begin
               rsp_theta_in = theta_ff;
               rsp_acc_in   = 1'b0;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   assign next_is_log = (state_in == S_LOGT) || (state_in == S_LOGC) ||
                        (state_in == S_PLT) || (state_in == S_PLC) || (state_in == S_LU);
   assign go_in       = next_is_log && (state_in != state_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         go_ff        <= 1'b0;
         job_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      theta_ff     <= theta_in;
      clt_ff       <= clt_in;
      clc_ff       <= clc_in;
      lt_ff        <= lt_in;
      lc_ff        <= lc_in;
      lu_ff        <= lu_in;
      tp_ff        <= tp_in;
      r_ff         <= r_in;
      u_ff         <= u_in;
      pa_ff        <= pa_in;
      prod_ff      <= mul_p;
      rsp_theta_ff <= rsp_theta_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sample_theta = rsp_theta_ff;
   assign rsp_ch.accepted     = rsp_acc_ff;
   assign rsp_ch.out_of_range = rsp_oor_ff;

`ifndef NO_ASSERTIONS
   a_log_done_in_log_state: assert property (@(posedge clock) disable iff (reset)
      log_st.done |-> (state_ff == S_LOGT || state_ff == S_LOGC || state_ff == S_PLT ||
                       state_ff == S_PLC || state_ff == S_LU))
      else $error("log result arrived outside a log state");

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      log_ctrl.start |-> !log_st.busy)
      else $error("log started while busy");

   a_theta_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (theta_ff != '0 && theta_ff < mbb_pkg::ONE_Q))
      else $error("theta left the open unit interval");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_acc_ff && rsp_oor_ff))
      else $error("accepted and out of range both set");

   a_single_transaction: assert property (@(posedge clock) disable iff (reset)
      take_req |=> !req_ch.ready)
      else $error("second transaction taken while one is in flight");
`endif
endmodule
